[sv/tis_pkg.sv]
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types, codes and tables for the tank indicator sequencer.
// ----------------------------------------------------------------------------
package tis_pkg;

    localparam int TICK_W   = 9;
    localparam int HOLD_W   = 8;
    localparam int BEEP_W   = 7;
    localparam int BEEPS_W  = 3;
    localparam int LEVEL_W  = 3;
    localparam int LEDS_W   = 5;
    localparam int MODE_W   = 2;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LEVEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MODE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LAST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ON     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_ON     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_RELOAD = 2'd3;

    localparam logic [TICK_W-1:0] RST_FRAME_LAST = 9'd300;
    localparam logic [TICK_W-1:0] RST_RUN_ON     = 9'd10;
    localparam logic [TICK_W-1:0] RST_DRY_ON     = 9'd150;
    localparam logic [HOLD_W-1:0] RST_DRY_RELOAD = 8'd20;
    localparam logic [HOLD_W-1:0] RST_DRY_HOLD   = 8'd20;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LEVEL_W-1:0]  level;
        logic [MODE_W-1:0]   new_pump_mode;
    } t_item;

    typedef struct packed {
        logic [LEDS_W-1:0] level_leds;
        logic              pump_led;
        logic              buzzer;
        logic [MODE_W-1:0] pump_mode;
    } t_result;

    typedef struct packed {
        logic [TICK_W-1:0] frame_last;
        logic [TICK_W-1:0] run_on_ticks;
        logic [TICK_W-1:0] dry_on_ticks;
        logic [HOLD_W-1:0] dry_hold_reload;
    } t_cfg;

    // beep length 10*(11-2*level); out-of-range levels stay silent
    function automatic logic [BEEP_W-1:0] beep_ticks(input logic [LEVEL_W-1:0] lv);
        logic [BEEP_W-1:0] r;
        case (lv)
            3'd0:    r = 7'd110;
            3'd1:    r = 7'd90;
            3'd2:    r = 7'd70;
            3'd3:    r = 7'd50;
            3'd4:    r = 7'd30;
            3'd5:    r = 7'd10;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [LEDS_W-1:0] thermo(input logic [LEVEL_W-1:0] lv);
        logic [LEDS_W-1:0] r;
        case (lv)
            3'd0:    r = 5'b00000;
            3'd1:    r = 5'b00001;
            3'd2:    r = 5'b00011;
            3'd3:    r = 5'b00111;
            3'd4:    r = 5'b01111;
            3'd5:    r = 5'b11111;
            default: r = 5'b00000;
        endcase
        return r;
    endfunction

endpackage

[sv/tis_cfg.sv]
// ----------------------------------------------------------------------------
// tis_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module tis_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tis_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tis_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tis_pkg::t_cfg                   o_cfg
);
    import tis_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_last      <= RST_FRAME_LAST;
            r_cfg.run_on_ticks    <= RST_RUN_ON;
            r_cfg.dry_on_ticks    <= RST_DRY_ON;
            r_cfg.dry_hold_reload <= RST_DRY_RELOAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_LAST: r_cfg.frame_last      <= i_cfg_data;
                CFG_RUN_ON:     r_cfg.run_on_ticks    <= i_cfg_data;
                CFG_DRY_ON:     r_cfg.dry_on_ticks    <= i_cfg_data;
                CFG_DRY_RELOAD: r_cfg.dry_hold_reload <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/tis_state.sv]
// ----------------------------------------------------------------------------
// tis_state
// Sequencer state and its update for one event, applied on each step.
// ----------------------------------------------------------------------------
module tis_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  tis_pkg::t_item   i_item,
    input  tis_pkg::t_cfg    i_cfg,
    output tis_pkg::t_result o_result
);
    import tis_pkg::*;

    logic [TICK_W-1:0]  r_frame_tick,   n_frame_tick;
    logic [TICK_W-1:0]  r_pump_on_time, n_pump_on_time;
    logic [BEEPS_W-1:0] r_beeps_left,   n_beeps_left;
    logic [BEEP_W-1:0]  r_beep_on_time, n_beep_on_time;
    logic [HOLD_W-1:0]  r_dry_hold,     n_dry_hold;
    logic [LEDS_W-1:0]  r_led_pattern,  n_led_pattern;
    logic [LEVEL_W-1:0] r_last_level,   n_last_level;
    logic [MODE_W-1:0]  r_mode,         n_mode;
    logic               r_pump_led,     n_pump_led;
    logic               r_buzzer,       n_buzzer;

    logic [TICK_W:0]    w_tick_inc;
    logic [HOLD_W-1:0]  w_hold_dec;
    logic               w_frame_start;

    assign w_tick_inc    = {1'b0, r_frame_tick} + {{TICK_W{1'b0}}, 1'b1};
    assign w_hold_dec    = r_dry_hold - {{(HOLD_W-1){1'b0}}, 1'b1};
    assign w_frame_start = (r_frame_tick == '0);

    always_comb begin
        n_frame_tick   = r_frame_tick;
        n_pump_on_time = r_pump_on_time;
        n_beeps_left   = r_beeps_left;
        n_beep_on_time = r_beep_on_time;
        n_dry_hold     = r_dry_hold;
        n_led_pattern  = r_led_pattern;
        n_last_level   = r_last_level;
        n_mode         = r_mode;
        n_pump_led     = r_pump_led;
        n_buzzer       = r_buzzer;

        case (i_item.action)
            ACT_TICK: begin
                if (r_pump_on_time == '0) begin
                    n_pump_led = 1'b0;
                end else begin
                    if (w_frame_start) begin
                        n_pump_led = 1'b1;
                        n_dry_hold = w_hold_dec;
                        // dry run expired: force pump off, LED drops next tick
                        if (r_mode == MODE_DRY && w_hold_dec == '0) begin
                            n_mode         = MODE_OFF;
                            n_pump_on_time = '0;
                            n_dry_hold     = i_cfg.dry_hold_reload;
                        end
                    end else if (r_frame_tick == r_pump_on_time) begin
                        n_pump_led = 1'b0;
                    end
                end

                if (r_beep_on_time == '0) begin
                    n_buzzer = 1'b0;
                end else if (r_beeps_left != '0) begin
                    if (w_frame_start) begin
                        n_buzzer = 1'b1;
                    end else if (r_frame_tick == {{(TICK_W-BEEP_W){1'b0}}, r_beep_on_time})
                    begin
                        n_buzzer     = 1'b0;
                        n_beeps_left = r_beeps_left - {{(BEEPS_W-1){1'b0}}, 1'b1};
                    end
                end

                if (w_tick_inc > {1'b0, i_cfg.frame_last}) begin
                    n_frame_tick = '0;
                end else begin
                    n_frame_tick = w_tick_inc[TICK_W-1:0];
                end
            end
            ACT_LEVEL: begin
                n_led_pattern = thermo(i_item.level);
                if (i_item.level != r_last_level) begin
                    n_beeps_left   = i_item.level;
                    n_beep_on_time = beep_ticks(i_item.level);
                end
                n_last_level = i_item.level;
            end
            ACT_MODE: begin
                case (i_item.new_pump_mode)
                    MODE_OFF: begin
                        n_mode         = MODE_OFF;
                        n_pump_on_time = '0;
                    end
                    MODE_RUN: begin
                        n_mode         = MODE_RUN;
                        n_pump_on_time = i_cfg.run_on_ticks;
                    end
                    MODE_DRY: begin
                        n_mode         = MODE_DRY;
                        n_pump_on_time = i_cfg.dry_on_ticks;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_tick   <= '0;
            r_pump_on_time <= '0;
            r_beeps_left   <= '0;
            r_beep_on_time <= '0;
            r_dry_hold     <= RST_DRY_HOLD;
            r_led_pattern  <= '0;
            r_last_level   <= '0;
            r_mode         <= MODE_OFF;
            r_pump_led     <= 1'b0;
            r_buzzer       <= 1'b0;
        end else if (i_step) begin
            r_frame_tick   <= n_frame_tick;
            r_pump_on_time <= n_pump_on_time;
            r_beeps_left   <= n_beeps_left;
            r_beep_on_time <= n_beep_on_time;
            r_dry_hold     <= n_dry_hold;
            r_led_pattern  <= n_led_pattern;
            r_last_level   <= n_last_level;
            r_mode         <= n_mode;
            r_pump_led     <= n_pump_led;
            r_buzzer       <= n_buzzer;
        end
    end

    assign o_result.level_leds = n_led_pattern;
    assign o_result.pump_led   = n_pump_led;
    assign o_result.buzzer     = n_buzzer;
    assign o_result.pump_mode  = n_mode;

endmodule

[sv/tank_indicator_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// tank_indicator_sequencer_unit
// The result is registered: an event passes the input register, then the result register.
// Throughput: one event per cycle while the result is accepted; the state updates once per event.
// A stalled result holds a full input register; the input stage drains only as the result stage advances.
// Synchronous active-low reset clears state (dry hold to its default), config to defaults, stages empty.
// ----------------------------------------------------------------------------
module tank_indicator_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tis_pkg::ACTION_W-1:0]    i_action,
    input  logic [tis_pkg::LEVEL_W-1:0]     i_level,
    input  logic [tis_pkg::MODE_W-1:0]      i_new_pump_mode,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tis_pkg::LEDS_W-1:0]      o_level_leds,
    output logic                            o_pump_led,
    output logic                            o_buzzer,
    output logic [tis_pkg::MODE_W-1:0]      o_pump_mode,
    input  logic                            i_cfg_we,
    input  logic [tis_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tis_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tis_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_item   r_item;
    t_result r_out;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_step;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    tis_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tis_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.action        <= i_action;
            r_item.level         <= i_level;
            r_item.new_pump_mode <= i_new_pump_mode;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_level_leds = r_out.level_leds;
    assign o_pump_led   = r_out.pump_led;
    assign o_buzzer     = r_out.buzzer;
    assign o_pump_mode  = r_out.pump_mode;

endmodule

[test/tank_indicator_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_indicator_sequencer_unit_tb
// Drives tick, level, pump-mode and no-op events through the valid/ready input and
// checks every output transfer against a cycle-free model of the indicator
// state. Runs a directed opening at reset settings, then random events
// under several register settings, with random stalls on both channels except in the last phase.
// ----------------------------------------------------------------------------
module tank_indicator_sequencer_unit_tb;

    import tis_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    class indicator_scoreboard;
        logic [TICK_W-1:0]  frame_last, run_on_ticks, dry_on_ticks;
        logic [HOLD_W-1:0]  hold_reload;
        logic [TICK_W-1:0]  frame_tick, pump_on_time;
        logic [BEEPS_W-1:0] beeps_left;
        logic [BEEP_W-1:0]  beep_on_time;
        logic [HOLD_W-1:0]  dry_hold;
        logic [LEDS_W-1:0]  led_pattern;
        logic [LEVEL_W-1:0] last_level;
        logic [MODE_W-1:0]  mode;
        logic               pump_led, buzzer;
        t_result            expected_outputs[$];
        int                 mismatches;

        function new();
            frame_last   = RST_FRAME_LAST;
            run_on_ticks = RST_RUN_ON;
            dry_on_ticks = RST_DRY_ON;
            hold_reload  = RST_DRY_RELOAD;
            frame_tick   = '0;
            pump_on_time = '0;
            beeps_left   = '0;
            beep_on_time = '0;
            dry_hold     = RST_DRY_HOLD;
            led_pattern  = '0;
            last_level   = '0;
            mode         = MODE_OFF;
            pump_led     = 1'b0;
            buzzer       = 1'b0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_LAST: frame_last   = data;
                CFG_RUN_ON:     run_on_ticks = data;
                CFG_DRY_ON:     dry_on_ticks = data;
                CFG_DRY_RELOAD: hold_reload  = data[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function void set_mode(logic [MODE_W-1:0] m);
            mode = m;
            case (m)
                MODE_OFF: pump_on_time = '0;
                MODE_RUN: pump_on_time = run_on_ticks;
                default:  pump_on_time = dry_on_ticks;
            endcase
        endfunction

        function void advance_tick();
            int nxt;
            if (pump_on_time == '0) begin
                pump_led = 1'b0;
            end else if (frame_tick == '0) begin
                pump_led = 1'b1;
                dry_hold = dry_hold - 8'd1;
                // forced stop: LED stays as is until the next tick
                if (mode == MODE_DRY && dry_hold == '0) begin
                    set_mode(MODE_OFF);
                    dry_hold = hold_reload;
                end
            end else if (frame_tick == pump_on_time) begin
                pump_led = 1'b0;
            end

            if (beep_on_time == '0) begin
                buzzer = 1'b0;
            end else if (beeps_left != '0) begin
                if (frame_tick == '0) begin
                    buzzer = 1'b1;
                end else if (frame_tick == TICK_W'(beep_on_time)) begin
                    buzzer     = 1'b0;
                    beeps_left = beeps_left - 3'd1;
                end
            end

            nxt = int'(frame_tick) + 1;
            frame_tick = (nxt > int'(frame_last)) ? '0 : TICK_W'(nxt);
        endfunction

        function void set_level(logic [LEVEL_W-1:0] lv);
            led_pattern = (lv <= LEVEL_MAX) ? LEDS_W'((1 << lv) - 1) : '0;
            if (lv != last_level) begin
                beeps_left   = lv;
                beep_on_time = (lv <= LEVEL_MAX) ? BEEP_W'(10 * (11 - 2 * int'(lv))) : '0;
            end
            last_level = lv;
        endfunction

        function void note_event(t_item ev);
            t_result r;
            case (ev.action)
                ACT_TICK:  advance_tick();
                ACT_LEVEL: set_level(ev.level);
                ACT_MODE:  if (ev.new_pump_mode != MODE_BAD) set_mode(ev.new_pump_mode);
                default: ;
            endcase
            r.level_leds = led_pattern;
            r.pump_led   = pump_led;
            r.buzzer     = buzzer;
            r.pump_mode  = mode;
            expected_outputs.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_outputs(t_result got);
            t_result want;
            if (expected_outputs.size() == 0) begin
                report_mismatch("unexpected transfer", got, 0);
                return;
            end
            want = expected_outputs.pop_front();
            if (got.level_leds !== want.level_leds)
                report_mismatch("level_leds", got.level_leds, want.level_leds);
            if (got.pump_led !== want.pump_led)
                report_mismatch("pump_led", got.pump_led, want.pump_led);
            if (got.buzzer !== want.buzzer)
                report_mismatch("buzzer", got.buzzer, want.buzzer);
            if (got.pump_mode !== want.pump_mode)
                report_mismatch("pump_mode", got.pump_mode, want.pump_mode);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [ACTION_W-1:0]   i_action = ACT_TICK;
    logic [LEVEL_W-1:0]    i_level = '0;
    logic [MODE_W-1:0]     i_new_pump_mode = MODE_OFF;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [LEDS_W-1:0]     o_level_leds;
    logic                  o_pump_led;
    logic                  o_buzzer;
    logic [MODE_W-1:0]     o_pump_mode;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FRAME_LAST;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    indicator_scoreboard   sb = new();
    bit                    gaps_on = 1'b1;
    t_result               seen_outputs;

    tank_indicator_sequencer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_level         (i_level),
        .i_new_pump_mode (i_new_pump_mode),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_level_leds    (o_level_leds),
        .o_pump_led      (o_pump_led),
        .o_buzzer        (o_buzzer),
        .o_pump_mode     (o_pump_mode),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // called at a falling edge, returns at a falling edge
    task send_event(logic [ACTION_W-1:0] act, logic [LEVEL_W-1:0] lv,
                    logic [MODE_W-1:0] m);
        t_item ev;
        ev.action        = act;
        ev.level         = lv;
        ev.new_pump_mode = m;
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_level         <= lv;
        i_new_pump_mode <= m;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_event(ev);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task wait_drained();
        while (sb.expected_outputs.size() != 0) @(negedge i_clk);
    endtask

    task run_phase(logic [TICK_W-1:0] fl, logic [TICK_W-1:0] run_on,
                   logic [TICK_W-1:0] dry_on, logic [HOLD_W-1:0] reload, int n_events);
        int                  r;
        int                  pick;
        logic [ACTION_W-1:0] act;
        logic [MODE_W-1:0]   m;
        i_in_valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        write_reg(CFG_FRAME_LAST, fl);
        write_reg(CFG_RUN_ON, run_on);
        write_reg(CFG_DRY_ON, dry_on);
        write_reg(CFG_DRY_RELOAD, CFG_DATA_W'(reload));
        i_cfg_we <= 1'b0;
        for (int k = 0; k < n_events; k++) begin
            r    = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            if (pick < 5)      m = MODE_DRY;
            else if (pick < 7) m = MODE_RUN;
            else if (pick < 9) m = MODE_OFF;
            else               m = MODE_BAD;
            if (r < 82)      act = ACT_TICK;
            else if (r < 92) act = ACT_LEVEL;
            else if (r < 98) act = ACT_MODE;
            else             act = ACT_NONE;
            send_event(act, LEVEL_W'($urandom_range(0, 7)), m);
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_outputs.level_leds = o_level_leds;
            seen_outputs.pump_led   = o_pump_led;
            seen_outputs.buzzer     = o_buzzer;
            seen_outputs.pump_mode  = o_pump_mode;
            sb.check_outputs(seen_outputs);
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening at reset register values
        send_event(ACT_TICK,  3'd0, MODE_OFF);
        send_event(ACT_LEVEL, 3'd3, MODE_OFF);
        send_event(ACT_LEVEL, 3'd3, MODE_OFF);
        send_event(ACT_LEVEL, 3'd5, MODE_OFF);
        send_event(ACT_TICK,  3'd0, MODE_OFF);
        send_event(ACT_LEVEL, 3'd7, MODE_OFF);
        send_event(ACT_LEVEL, 3'd6, MODE_OFF);
        send_event(ACT_LEVEL, 3'd0, MODE_OFF);
        send_event(ACT_LEVEL, 3'd1, MODE_OFF);
        send_event(ACT_LEVEL, 3'd2, MODE_OFF);
        send_event(ACT_LEVEL, 3'd4, MODE_OFF);
        send_event(ACT_MODE,  3'd0, MODE_RUN);
        send_event(ACT_TICK,  3'd0, MODE_OFF);
        send_event(ACT_MODE,  3'd0, MODE_DRY);
        send_event(ACT_MODE,  3'd0, MODE_BAD);
        send_event(ACT_NONE,  3'd7, MODE_BAD);
        send_event(ACT_TICK,  3'd7, MODE_BAD);
        send_event(ACT_MODE,  3'd0, MODE_OFF);
        send_event(ACT_TICK,  3'd0, MODE_OFF);
        send_event(ACT_LEVEL, 3'd5, MODE_DRY);
        send_event(ACT_TICK,  3'd0, MODE_OFF);

        run_phase(9'd7,   9'd3,   9'd5,   8'd2,   150);
        run_phase(9'd120, 9'd20,  9'd60,  8'd1,   180);
        run_phase(9'd1,   9'd1,   9'd1,   8'd255, 150);
        run_phase(9'd511, 9'd511, 9'd511, 8'd255, 100);
        run_phase(9'd0,   9'd5,   9'd5,   8'd0,   80);
        run_phase(9'd15,  9'd4,   9'd9,   8'd3,   150);
        run_phase(9'd40,  9'd12,  9'd30,  8'd5,   150);
        gaps_on = 1'b0;
        run_phase(9'd3,   9'd2,   9'd3,   8'd1,   250);
        i_in_valid <= 1'b0;

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (sb.expected_outputs.size() != 0)
            sb.report_mismatch("missing transfers", 0, sb.expected_outputs.size());
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
